### rtl/core/pts_pkg.sv
// shared constants and types for the priority task selector
// no dependencies; used by pts_cell, pts_ctrl and priority_task_selector_top
`default_nettype none

package pts_pkg;

   localparam int TASK_SLOTS_DEFAULT = 16;
   localparam int PRIO_W             = 8;
   localparam int OUT_IDX_W          = 4;
   localparam logic [PRIO_W-1:0] IDLE_PRIORITY = 8'd255;

   typedef enum logic {
      OP_CREATE   = 1'b0,
      OP_SCHEDULE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

endpackage

`default_nettype wire

### rtl/core/pts_cell.sv
// one slot of the task table: holds a priority byte and one stage of the
// minimum-search token that walks the chain; depends on pts_pkg
`default_nettype none

module pts_cell #(
   parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEFAULT,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(TASK_SLOTS)-1:0]  wr_slot,
   input  wire logic [pts_pkg::PRIO_W-1:0]     wr_prio,
   input  wire logic [$clog2(TASK_SLOTS+1)-1:0] task_count,
   input  wire logic [$clog2(TASK_SLOTS)-1:0]  running_task,
   input  wire logic                           tok_valid_i,
   input  wire logic [pts_pkg::PRIO_W-1:0]     tok_prio_i,
   input  wire logic [$clog2(TASK_SLOTS)-1:0]  tok_idx_i,
   output logic                                tok_valid_o,
   output logic [pts_pkg::PRIO_W-1:0]          tok_prio_o,
   output logic [$clog2(TASK_SLOTS)-1:0]       tok_idx_o
);

   localparam int IDX_W = $clog2(TASK_SLOTS);
   localparam int CNT_W = $clog2(TASK_SLOTS+1);

   logic [pts_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic                       tok_valid_ff;
   logic [pts_pkg::PRIO_W-1:0] tok_prio_ff, tok_prio_in;
   logic [IDX_W-1:0]           tok_idx_ff, tok_idx_in;
   logic                       filled, is_running, take;

   assign filled     = CNT_W'(CELL_INDEX) < task_count;
   assign is_running = running_task == IDX_W'(CELL_INDEX);
   // strictly smaller keeps the lowest index on ties
   assign take       = filled && !is_running && (prio_ff < tok_prio_i);

   always_comb begin
      prio_in = prio_ff;
      if (wr_en && (wr_slot == IDX_W'(CELL_INDEX))) begin
         prio_in = wr_prio;
      end
      tok_prio_in = tok_prio_i;
      tok_idx_in  = tok_idx_i;
      if (take) begin
         tok_prio_in = prio_ff;
         tok_idx_in  = IDX_W'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      prio_ff     <= prio_in;
      tok_prio_ff <= tok_prio_in;
      tok_idx_ff  <= tok_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_i;
      end
   end

   assign tok_valid_o = tok_valid_ff;
   assign tok_prio_o  = tok_prio_ff;
   assign tok_idx_o   = tok_idx_ff;

endmodule

`default_nettype wire

### rtl/core/pts_ctrl.sv
// request sequencer: task count, running task, result register and
// launch of the search token into the cell chain; depends on pts_pkg
`default_nettype none

module pts_ctrl #(
   parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_op,
   input  wire logic [pts_pkg::PRIO_W-1:0]      req_priority_req,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [pts_pkg::OUT_IDX_W-1:0]        rsp_task_index,
   output logic [pts_pkg::OUT_IDX_W-1:0]        rsp_previous_index,
   output logic                                 wr_en,
   output logic [$clog2(TASK_SLOTS)-1:0]        wr_slot,
   output logic [pts_pkg::PRIO_W-1:0]           wr_prio,
   output logic [$clog2(TASK_SLOTS+1)-1:0]      task_count,
   output logic [$clog2(TASK_SLOTS)-1:0]        running_task,
   output logic                                 launch,
   input  wire logic                            scan_valid,
   input  wire logic [$clog2(TASK_SLOTS)-1:0]   scan_idx
);

   localparam int IDX_W = $clog2(TASK_SLOTS);
   localparam int CNT_W = $clog2(TASK_SLOTS+1);
   localparam int OW    = pts_pkg::OUT_IDX_W;

   pts_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       running_ff, running_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [OW-1:0]          rsp_index_ff, rsp_index_in;
   logic [OW-1:0]          rsp_prev_ff, rsp_prev_in;
   logic                   req_acc, full;
   logic [IDX_W+OW-1:0]    slot_ext, scan_ext, running_ext;

   // index fields carry only the low bits of wide slot numbers
   assign slot_ext    = {{OW{1'b0}}, count_ff[IDX_W-1:0]};
   assign scan_ext    = {{OW{1'b0}}, scan_idx};
   assign running_ext = {{OW{1'b0}}, running_ff};

   assign full      = count_ff == CNT_W'(TASK_SLOTS);
   assign req_stall = (state_ff != pts_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      running_in    = running_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_prev_in   = rsp_prev_ff;
      wr_en         = 1'b0;
      launch        = 1'b0;
      case (state_ff)
         pts_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_op == pts_pkg::OP_CREATE) begin
                  rsp_valid_in = 1'b1;
                  rsp_prev_in  = '0;
                  if (full) begin
                     rsp_status_in = pts_pkg::STATUS_FULL;
                     rsp_index_in  = '0;
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     rsp_status_in = pts_pkg::STATUS_OK;
                     rsp_index_in  = slot_ext[OW-1:0];
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = pts_pkg::STATUS_EMPTY;
                  rsp_index_in  = running_ext[OW-1:0];
                  rsp_prev_in   = running_ext[OW-1:0];
               end else begin
                  launch   = 1'b1;
                  state_in = pts_pkg::ST_SCAN;
               end
            end
         end
         pts_pkg::ST_SCAN: begin
            // output register drained before the scan started, so it is free here
            if (scan_valid) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pts_pkg::STATUS_OK;
               rsp_index_in  = scan_ext[OW-1:0];
               rsp_prev_in   = running_ext[OW-1:0];
               running_in    = scan_idx;
               state_in      = pts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pts_pkg::ST_IDLE;
         count_ff     <= '0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_prev_ff   <= rsp_prev_in;
   end

   assign wr_slot            = count_ff[IDX_W-1:0];
   assign wr_prio            = req_priority_req;
   assign task_count         = count_ff;
   assign running_task       = running_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_task_index     = rsp_index_ff;
   assign rsp_previous_index = rsp_prev_ff;

   a_scan_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_valid |-> (state_ff == pts_pkg::ST_SCAN))
      else $error("search token left the chain outside a scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TASK_SLOTS))
      else $error("task count above table size");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !$past(reset)) |-> $past(req_acc || scan_valid))
      else $error("response without request or finished scan");

   a_running_change: assert property (@(posedge clock) disable iff (reset)
      (!$stable(running_ff) && !$past(reset)) |-> $past(scan_valid))
      else $error("running task changed outside a schedule");

endmodule

`default_nettype wire

### rtl/core/priority_task_selector_top.sv
// priority task selector: create requests fill the next slot, schedule
// requests pick the most urgent other slot. create: result registered in the
// cycle after acceptance. schedule: token walks the TASK_SLOTS cell registers,
// then the result register. one request in flight at a time; a new request
// is taken once the result register is free or being taken.
// reset clears task count, running task and token valids; the table is not cleared
`default_nettype none

module priority_task_selector_top #(
   parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_op,
   input  wire logic [pts_pkg::PRIO_W-1:0]   req_priority_req,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [pts_pkg::OUT_IDX_W-1:0]     rsp_task_index,
   output logic [pts_pkg::OUT_IDX_W-1:0]     rsp_previous_index
);

   localparam int IDX_W = $clog2(TASK_SLOTS);
   localparam int CNT_W = $clog2(TASK_SLOTS+1);

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_slot;
   logic [pts_pkg::PRIO_W-1:0]  wr_prio;
   logic [CNT_W-1:0]            task_count;
   logic [IDX_W-1:0]            running_task;
   logic                        launch;

   logic                        tok_valid [TASK_SLOTS+1];
   logic [pts_pkg::PRIO_W-1:0]  tok_prio  [TASK_SLOTS+1];
   logic [IDX_W-1:0]            tok_idx   [TASK_SLOTS+1];

   // token enters with the idle priority and slot 0 as the fallback choice
   assign tok_valid[0] = launch;
   assign tok_prio[0]  = pts_pkg::IDLE_PRIORITY;
   assign tok_idx[0]   = '0;

   pts_ctrl #(
      .TASK_SLOTS(TASK_SLOTS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_task_index     (rsp_task_index),
      .rsp_previous_index (rsp_previous_index),
      .wr_en              (wr_en),
      .wr_slot            (wr_slot),
      .wr_prio            (wr_prio),
      .task_count         (task_count),
      .running_task       (running_task),
      .launch             (launch),
      .scan_valid         (tok_valid[TASK_SLOTS]),
      .scan_idx           (tok_idx[TASK_SLOTS])
   );

   for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
      pts_cell #(
         .TASK_SLOTS(TASK_SLOTS),
         .CELL_INDEX(g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .wr_en        (wr_en),
         .wr_slot      (wr_slot),
         .wr_prio      (wr_prio),
         .task_count   (task_count),
         .running_task (running_task),
         .tok_valid_i  (tok_valid[g]),
         .tok_prio_i   (tok_prio[g]),
         .tok_idx_i    (tok_idx[g]),
         .tok_valid_o  (tok_valid[g+1]),
         .tok_prio_o   (tok_prio[g+1]),
         .tok_idx_o    (tok_idx[g+1])
      );
   end

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench for priority_task_selector_top: random create/schedule requests
// checked against a task table predictor held in a small scoreboard class
// depends on pts_pkg and priority_task_selector_top

package task_table_check_pkg;
   import pts_pkg::*;

   localparam int SLOT_COUNT = TASK_SLOTS_DEFAULT;

   typedef struct packed {
      status_type             status;
      logic [OUT_IDX_W-1:0]   task_index;
      logic [OUT_IDX_W-1:0]   previous_index;
   } selection_result;

   class task_table_scoreboard;
      logic [PRIO_W-1:0] prio_table [SLOT_COUNT];
      int unsigned       filled;
      int unsigned       running;
      int unsigned       error_count;
      selection_result   expected_q [$];

      function new();
         filled      = 0;
         running     = 0;
         error_count = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // work out the result of one accepted request and queue it
      function void note_request(op_type op, logic [PRIO_W-1:0] prio);
         selection_result r;
         int unsigned     best_prio;
         int unsigned     best_idx;
         r.status         = STATUS_OK;
         r.task_index     = '0;
         r.previous_index = '0;
         if (op == OP_CREATE) begin
            if (filled >= SLOT_COUNT) begin
               r.status = STATUS_FULL;
            end else begin
               prio_table[filled] = prio;
               r.task_index       = OUT_IDX_W'(filled);
               filled++;
            end
         end else if (filled == 0) begin
            r.status         = STATUS_EMPTY;
            r.task_index     = OUT_IDX_W'(running);
            r.previous_index = OUT_IDX_W'(running);
         end else begin
            best_prio = IDLE_PRIORITY;
            best_idx  = 0;
            for (int i = 0; i < filled; i++) begin
               if (i != running && prio_table[i] < best_prio) begin
                  best_prio = prio_table[i];
                  best_idx  = i;
               end
            end
            r.task_index     = OUT_IDX_W'(best_idx);
            r.previous_index = OUT_IDX_W'(running);
            running          = best_idx;
         end
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
         error_count++;
      endtask

      task check_response(status_type status, logic [OUT_IDX_W-1:0] task_index,
                          logic [OUT_IDX_W-1:0] previous_index);
         selection_result want;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response, status", status, 0);
         end else begin
            want = expected_q.pop_front();
            if (status !== want.status)
               report_mismatch("status", status, want.status);
            if (task_index !== want.task_index)
               report_mismatch("task_index", task_index, want.task_index);
            if (previous_index !== want.previous_index)
               report_mismatch("previous_index", previous_index, want.previous_index);
         end
      endtask
   endclass
endpackage

module testbench;
   import pts_pkg::*;
   import task_table_check_pkg::*;

   localparam int RANDOM_ITEMS = 1930;
   localparam int CYCLE_LIMIT  = 400000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_op;
   logic [PRIO_W-1:0]       req_priority_req;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [1:0]              rsp_status;
   logic [OUT_IDX_W-1:0]    rsp_task_index;
   logic [OUT_IDX_W-1:0]    rsp_previous_index;

   task_table_scoreboard sb;
   bit                   idling_on;
   int                   stall_left;
   int                   cycle_count;

   priority_task_selector_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_task_index     (rsp_task_index),
      .rsp_previous_index (rsp_previous_index)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // favor ties, the idle priority and values just below it
   function automatic logic [PRIO_W-1:0] pick_priority();
      case ($urandom_range(0, 4))
         0: return 8'd0;
         1: return IDLE_PRIORITY;
         2: return PRIO_W'($urandom_range(0, 3));
         3: return PRIO_W'($urandom_range(250, 254));
         default: return PRIO_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_request(op_type op, logic [PRIO_W-1:0] prio);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_priority_req <= prio;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, prio);
   endtask

   // hold off new requests until every pending result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (idling_on && !reset && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(1, 7);
         rsp_stall  <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(status_type'(rsp_status), rsp_task_index, rsp_previous_index);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      op_type op;
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_CREATE;
      req_priority_req = '0;
      rsp_stall        = 1'b0;
      stall_left       = 0;
      cycle_count      = 0;
      idling_on        = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table, lone running task, all others idle, ties, then a mix
      send_request(OP_SCHEDULE, 8'h00);
      send_request(OP_CREATE,   8'hff);
      send_request(OP_SCHEDULE, 8'h5a);
      send_request(OP_CREATE,   8'hff);
      send_request(OP_CREATE,   8'hff);
      send_request(OP_SCHEDULE, 8'ha5);
      send_request(OP_CREATE,   8'h00);
      send_request(OP_CREATE,   8'h00);
      send_request(OP_SCHEDULE, 8'hff);
      send_request(OP_SCHEDULE, 8'h00);
      send_request(OP_SCHEDULE, 8'h33);
      send_request(OP_CREATE,   8'h80);
      send_request(OP_CREATE,   8'h01);
      send_request(OP_CREATE,   8'hfe);
      send_request(OP_SCHEDULE, 8'hcc);
      send_request(OP_SCHEDULE, 8'h0f);
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idling_on = !((i >= 800 && i < 1000) || i >= RANDOM_ITEMS - 300);
         if (i == 500 || i == 1200)
            drain();
         // slow fill so schedules see many table sizes; later creates hit a full table
         if (sb.filled < SLOT_COUNT)
            op = ($urandom_range(0, 9) == 0) ? OP_CREATE : OP_SCHEDULE;
         else
            op = ($urandom_range(0, 7) == 0) ? OP_CREATE : OP_SCHEDULE;
         send_request(op, pick_priority());
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (SLOT_COUNT + 4) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
